[sv/sfr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hFF;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'hCC;
  localparam logic [15:0] CRC_POLY        = 16'h1021;
  localparam logic [15:0] CRC_MASK        = 16'hFFFF;

  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  localparam logic CMD_BYTE    = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic {
    ST_RUN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic step;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic out_free;
    logic rd_last;
  } dp_status_t;

  // One byte of CRC-16/XMODEM, MSB first.
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = ({c[14:0], 1'b0} ^ CRC_POLY) & CRC_MASK;
      end else begin
        c = {c[14:0], 1'b0} & CRC_MASK;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/sync_frame_receiver_crc16.sv]
// After its last CRC byte is taken, a frame's words are loaded in ST_EMIT.
// The run of FRAME_LENGTH-4 words leaves at one word per cycle when not stalled;
// the input stalls while the run is loaded into the output register.
// Other bytes are taken one per cycle; the CRC byte update is done within that cycle.
// Reset is asynchronous and active low; the payload store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_receiver_crc16 #(
  parameter int FRAME_LENGTH = 9
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       command_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      data_byte_o,
  output logic [3:0]      byte_index_o,
  output logic            crc_ok_o,
  output logic            last_o
);
  import sfr_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sfr_dp #(
    .FRAME_LENGTH (FRAME_LENGTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .command_i    (command_i),
    .rx_byte_i    (rx_byte_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_byte_o  (data_byte_o),
    .byte_index_o (byte_index_o),
    .crc_ok_o     (crc_ok_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

[sv/sfr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfr_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sfr_pkg::dp_status_t status_i,
  output sfr_pkg::ctrl_cmd_t      cmd_o
);
  import sfr_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_valid_i && status_i.frame_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free && status_i.rd_last) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      ST_RUN: begin
        in_stall_o = 1'b0;
        cmd_o.step = in_valid_i;
      end
      ST_EMIT: begin
        cmd_o.load = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/sfr_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module sfr_dp #(
  parameter int FRAME_LENGTH = 9
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i,
  input  wire logic               command_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire sfr_pkg::ctrl_cmd_t cmd_i,
  output sfr_pkg::dp_status_t     status_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              data_byte_o,
  output logic [3:0]              byte_index_o,
  output logic                    crc_ok_o,
  output logic                    last_o
);
  import sfr_pkg::*;

  localparam int         PayloadLen = FRAME_LENGTH - 4;
  localparam int         IdxW       = (PayloadLen > 1) ? $clog2(PayloadLen) : 1;
  localparam logic [4:0] PosCrcHi   = 5'(FRAME_LENGTH - 2);
  localparam logic [4:0] PosCrcLo   = 5'(FRAME_LENGTH - 1);
  localparam logic [4:0] PosFirst   = 5'd0;
  localparam logic [4:0] PosSecond  = 5'd1;
  localparam logic [4:0] PosPayload = 5'd2;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(PayloadLen - 1);

  logic [7:0]      sync_first_q, sync_second_q;
  logic [4:0]      pos_q;
  logic [15:0]     crc_q;
  logic [7:0]      crc_hi_q;
  logic            held_q;
  logic            ok_q;
  logic [IdxW-1:0] rd_idx_q;
  logic [7:0]      store_q [PayloadLen];
  logic [4:0]      pos_off;
  logic [IdxW-1:0] wr_idx;
  logic            is_byte;

  assign is_byte = (command_i == CMD_BYTE) && !held_q;
  assign pos_off = pos_q - PosPayload;
  assign wr_idx  = pos_off[IdxW-1:0];

  assign status_o.frame_done = is_byte && (pos_q == PosCrcLo);
  assign status_o.out_free   = !out_valid_o || !out_stall_i;
  assign status_o.rd_last    = (rd_idx_q == IdxLast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SYNC_FIRST_RST;
      sync_second_q <= SYNC_SECOND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosFirst;
      crc_q    <= '0;
      crc_hi_q <= '0;
      held_q   <= 1'b0;
      ok_q     <= 1'b0;
    end else if (cmd_i.step) begin
      if (command_i == CMD_RELEASE) begin
        held_q <= 1'b0;
      end else if (!held_q) begin
        if (pos_q == PosFirst) begin
          if (rx_byte_i == sync_first_q) begin
            pos_q <= PosSecond;
            crc_q <= '0;
          end
        end else if (pos_q == PosSecond) begin
          pos_q <= (rx_byte_i == sync_second_q) ? PosPayload : PosFirst;
          crc_q <= '0;
        end else if (pos_q < PosCrcHi) begin
          crc_q <= crc_add_byte(crc_q, rx_byte_i);
          pos_q <= pos_q + 5'd1;
        end else if (pos_q == PosCrcHi) begin
          crc_hi_q <= rx_byte_i;
          pos_q    <= pos_q + 5'd1;
        end else if (pos_q == PosCrcLo) begin
          ok_q   <= ({crc_hi_q, rx_byte_i} == crc_q);
          held_q <= 1'b1;
          pos_q  <= PosFirst;
          crc_q  <= '0;
        end else begin
          pos_q <= PosFirst;
          crc_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && is_byte && (pos_q >= PosPayload) && (pos_q < PosCrcHi)) begin
      store_q[wr_idx] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      rd_idx_q    <= '0;
    end else if (cmd_i.load) begin
      out_valid_o <= 1'b1;
      rd_idx_q    <= status_o.rd_last ? '0 : rd_idx_q + IdxW'(1);
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      data_byte_o  <= store_q[rd_idx_q];
      byte_index_o <= 4'(rd_idx_q);
      crc_ok_o     <= ok_q;
      last_o       <= status_o.rd_last;
    end
  end

endmodule

`default_nettype wire

[verif/sync_frame_receiver_crc16_tb.sv]
`timescale 1ns / 1ps

module sync_frame_receiver_crc16_tb;
  import sfr_pkg::*;

  localparam int FRAME_LEN = 9;
  localparam int PAYLOAD_LEN = FRAME_LEN - 4;
  localparam int POS_CRC_HI = FRAME_LEN - 2;
  localparam int PHASE_WORDS = 61;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] idx;
    logic       ok;
    logic       last;
  } payload_word_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] b;
    logic       typed;
    logic [2:0] n;
    logic       ok;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_idx_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       command_i;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] data_byte_o;
  logic [3:0] byte_index_o;
  logic       crc_ok_o;
  logic       last_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_count = 0;

  payload_word_t pending_words[$];

  logic [7:0]  sync_first_q;
  logic [7:0]  sync_second_q;
  int unsigned frame_pos;
  logic [15:0] frame_crc;
  logic [7:0]  payload_q [PAYLOAD_LEN];
  logic [7:0]  crc_hi_q;
  logic        holding;

  stim_row_t dir_rows [25];

  sync_frame_receiver_crc16 #(
    .FRAME_LENGTH(FRAME_LEN)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_byte_o (data_byte_o),
    .byte_index_o(byte_index_o),
    .crc_ok_o    (crc_ok_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      if (r[15] ^ d[i]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  task automatic predict_word(input logic cmd, input logic [7:0] b, output int n,
                              output logic ok);
    payload_word_t w;
    n = 0;
    ok = 1'b0;
    if (cmd == CMD_RELEASE) begin
      holding = 1'b0;
    end else if (!holding) begin
      if (frame_pos == 0) begin
        if (b == sync_first_q) begin
          frame_pos = 1;
          frame_crc = '0;
        end
      end else if (frame_pos == 1) begin
        frame_pos = (b == sync_second_q) ? 2 : 0;
        frame_crc = '0;
      end else if (frame_pos < POS_CRC_HI) begin
        payload_q[frame_pos - 2] = b;
        frame_crc = crc_next(frame_crc, b);
        frame_pos++;
      end else if (frame_pos == POS_CRC_HI) begin
        crc_hi_q = b;
        frame_pos++;
      end else begin
        ok = ({crc_hi_q, b} == frame_crc);
        for (int k = 0; k < PAYLOAD_LEN; k++) begin
          w.data = payload_q[k];
          w.idx = 4'(k);
          w.ok = ok;
          w.last = (k == PAYLOAD_LEN - 1);
          pending_words.push_back(w);
        end
        n = PAYLOAD_LEN;
        holding = 1'b1;
        frame_pos = 0;
        frame_crc = '0;
      end
    end
  endtask

  task automatic push_word(input logic cmd, input logic [7:0] b, output int n,
                           output logic ok);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(cmd, b, n, ok);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    if (idx == CFG_SYNC_FIRST) begin
      sync_first_q = v;
    end else begin
      sync_second_q = v;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_out
    payload_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: data_byte %0h byte_index %0d", data_byte_o, byte_index_o);
        fail_count++;
      end else begin
        want = pending_words.pop_front();
        if (data_byte_o !== want.data) begin
          $error("data_byte: expected %0h, got %0h", want.data, data_byte_o);
          fail_count++;
        end
        if (byte_index_o !== want.idx) begin
          $error("byte_index: expected %0d, got %0d", want.idx, byte_index_o);
          fail_count++;
        end
        if (crc_ok_o !== want.ok) begin
          $error("crc_ok: expected %0b, got %0b", want.ok, crc_ok_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int          n_res;
    logic        ok_res;
    int          kind;
    int          phase_count;
    int          extra;
    logic [7:0]  pay [PAYLOAD_LEN];
    logic [15:0] good_crc;
    logic [7:0]  v;

    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_SYNC_FIRST;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    command_i <= CMD_BYTE;
    rx_byte_i <= '0;
    out_stall_i <= 1'b0;

    sync_first_q = SYNC_FIRST_RST;
    sync_second_q = SYNC_SECOND_RST;
    frame_pos = 0;
    frame_crc = '0;
    crc_hi_q = '0;
    holding = 1'b0;

    dir_rows = '{
      '{CMD_BYTE,    8'h00, 1'b1, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hFF, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hFF, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hCC, 1'b1, 3'd0, 1'b0},
      '{CMD_RELEASE, 8'h00, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hFF, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hCC, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'h00, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'h00, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'h00, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'h00, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'h00, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'h00, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'h00, 1'b1, 3'd5, 1'b1},
      '{CMD_BYTE,    8'h55, 1'b1, 3'd0, 1'b0},
      '{CMD_RELEASE, 8'hA5, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hFF, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hCC, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hFF, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hFF, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hFF, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hFF, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hFF, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hFF, 1'b0, 3'd0, 1'b0},
      '{CMD_BYTE,    8'hFF, 1'b0, 3'd0, 1'b0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      push_word(dir_rows[i].cmd, dir_rows[i].b, n_res, ok_res);
      if (dir_rows[i].typed) begin
        if (n_res != int'(dir_rows[i].n)) begin
          $error("result count: expected %0d, got %0d", dir_rows[i].n, n_res);
          fail_count++;
        end else if (n_res != 0 && ok_res !== dir_rows[i].ok) begin
          $error("crc_ok: expected %0b, got %0b", dir_rows[i].ok, ok_res);
          fail_count++;
        end
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      in_valid_i <= 1'b0;
      while (pending_words.size() != 0) @(posedge clk_i);
      repeat (8) @(posedge clk_i);
      case (phase)
        0: begin
          write_reg(CFG_SYNC_FIRST, 8'h00);
          write_reg(CFG_SYNC_SECOND, 8'hFF);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_reg(CFG_SYNC_FIRST, 8'hFF);
          write_reg(CFG_SYNC_SECOND, 8'h00);
          send_idle_pct = 56;
          recv_stall_pct = 0;
        end
        2: begin
          write_reg(CFG_SYNC_FIRST, 8'($urandom_range(0, 255)));
          write_reg(CFG_SYNC_SECOND, 8'($urandom_range(0, 255)));
          send_idle_pct = 0;
          recv_stall_pct = 56;
        end
        default: begin
          v = 8'($urandom_range(0, 255));
          write_reg(CFG_SYNC_FIRST, v);
          write_reg(CFG_SYNC_SECOND, v);
          send_idle_pct = 14;
          recv_stall_pct = 14;
        end
      endcase
      cfg_we_i <= 1'b0;

      phase_count = 0;
      while (phase_count < PHASE_WORDS) begin
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          good_crc = '0;
          for (int k = 0; k < PAYLOAD_LEN; k++) begin
            if ($urandom_range(0, 7) == 0) begin
              pay[k] = {8{$urandom_range(0, 1) == 1}};
            end else begin
              pay[k] = 8'($urandom_range(0, 255));
            end
            good_crc = crc_next(good_crc, pay[k]);
          end
          if ($urandom_range(0, 4) == 0) begin
            good_crc ^= 16'(1 << $urandom_range(0, 15));
          end
          push_word(CMD_BYTE, sync_first_q, n_res, ok_res);
          push_word(CMD_BYTE, sync_second_q, n_res, ok_res);
          foreach (pay[k]) push_word(CMD_BYTE, pay[k], n_res, ok_res);
          push_word(CMD_BYTE, good_crc[15:8], n_res, ok_res);
          push_word(CMD_BYTE, good_crc[7:0], n_res, ok_res);
          extra = $urandom_range(0, 2);
          repeat (extra) push_word(CMD_BYTE, 8'($urandom_range(0, 255)), n_res, ok_res);
          push_word(CMD_RELEASE, 8'($urandom_range(0, 255)), n_res, ok_res);
          phase_count += FRAME_LEN + extra + 1;
        end else if (kind < 75) begin
          push_word(CMD_BYTE, sync_first_q, n_res, ok_res);
          push_word(CMD_BYTE, 8'($urandom_range(0, 255)), n_res, ok_res);
          phase_count += 2;
        end else if (kind < 85) begin
          push_word(CMD_BYTE, sync_first_q, n_res, ok_res);
          push_word(CMD_BYTE, sync_second_q, n_res, ok_res);
          extra = $urandom_range(0, 6);
          repeat (extra) push_word(CMD_BYTE, 8'($urandom_range(0, 255)), n_res, ok_res);
          phase_count += 2 + extra;
        end else if ($urandom_range(0, 1) == 0) begin
          push_word(CMD_RELEASE, 8'($urandom_range(0, 255)), n_res, ok_res);
          phase_count++;
        end else begin
          push_word(CMD_BYTE, 8'($urandom_range(0, 255)), n_res, ok_res);
          phase_count++;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/sfr_pkg.sv
sv/sfr_ctrl.sv
sv/sfr_dp.sv
sv/sync_frame_receiver_crc16.sv
verif/sync_frame_receiver_crc16_tb.sv
